// ===== rtl/core/gpsc_pkg.sv =====
// Shared constants, types and lookup functions of the gauge pointer stepper controller.
`default_nettype none

package gpsc_pkg;

	localparam int PosWidthDefault = 10;
	localparam int PosWidthMax     = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_STEP_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_CHUNK_STEPS   = 2'd1;
	localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd2;
	localparam logic [1:0] CFG_FULL_SCALE    = 2'd3;

	localparam logic [15:0] StepIntervalReset = 16'd200;
	localparam logic [3:0]  ChunkStepsReset   = 4'd10;
	localparam logic [9:0]  DebounceReset     = 10'd50;
	localparam logic [9:0]  FullScaleReset    = 10'd350;

	localparam logic [3:0]  MaxChunk    = 4'd10;
	localparam logic [15:0] ChunkSat    = 16'hFFFF;
	localparam logic [9:0]  DebounceSat = 10'h3FF;
	localparam logic [6:0]  PctMax      = 7'd100;

	// floor(x / 100) == (x * 167773) >> 24 for every x below 2^17
	localparam logic [17:0] Recip100   = 18'd167773;
	localparam int          RecipShift = 24;

	localparam logic [1:0] MODE_MOISTURE = 2'd0;
	localparam logic [1:0] MODE_LIGHT    = 2'd1;
	localparam logic [1:0] MODE_HEALTH   = 2'd2;

	typedef struct packed {
		logic capture;
		logic rt_mul;
		logic rt_div;
		logic rt_sub;
		logic btn_eval;
		logic motion_eval;
		logic step;
		logic idle_emit;
	} gpsc_cmd_t;

	typedef struct packed {
		logic sensor;
		logic press;
		logic go;
		logic last_step;
		logic out_free;
	} gpsc_sts_t;

	function automatic logic [3:0] coil_of(input logic [1:0] ph);
		logic [3:0] c;
		case (ph)
			2'd0: c = 4'b1010;
			2'd1: c = 4'b0110;
			2'd2: c = 4'b0101;
			2'd3: c = 4'b1001;
			default: c = 4'b1010;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] led_of(input logic [1:0] m);
		logic [2:0] l;
		case (m)
			MODE_MOISTURE: l = 3'b001;
			MODE_LIGHT:    l = 3'b100;
			MODE_HEALTH:   l = 3'b101;
			default:       l = 3'b001;
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpsc_ctrl.sv =====
// Sequencing state machine of the gauge pointer stepper controller.
`default_nettype none

module gpsc_ctrl
	import gpsc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire gpsc_sts_t sts,
	output gpsc_cmd_t      cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SENSE  = 9'b000000010,
		S_RT_MUL = 9'b000000100,
		S_RT_DIV = 9'b000001000,
		S_RT_SUB = 9'b000010000,
		S_BUTTON = 9'b000100000,
		S_MOTION = 9'b001000000,
		S_STEP   = 9'b010000000,
		S_HOLD   = 9'b100000000
	} gpsc_state_t;

	gpsc_state_t state_q, state_d;
	logic        from_btn_q, from_btn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			from_btn_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			from_btn_q <= from_btn_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		from_btn_d = from_btn_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_SENSE;
			end
			S_SENSE: begin
				if (sts.sensor) begin
					from_btn_d = 1'b0;
					state_d    = S_RT_MUL;
				end else begin
					state_d = S_BUTTON;
				end
			end
			S_RT_MUL: begin
				cmd.rt_mul = 1'b1;
				state_d    = S_RT_DIV;
			end
			S_RT_DIV: begin
				cmd.rt_div = 1'b1;
				state_d    = S_RT_SUB;
			end
			S_RT_SUB: begin
				cmd.rt_sub = 1'b1;
				state_d    = from_btn_q ? S_MOTION : S_BUTTON;
			end
			S_BUTTON: begin
				cmd.btn_eval = 1'b1;
				if (sts.press) begin
					from_btn_d = 1'b1;
					state_d    = S_RT_MUL;
				end else begin
					state_d = S_MOTION;
				end
			end
			S_MOTION: begin
				cmd.motion_eval = 1'b1;
				state_d         = sts.go ? S_STEP : S_HOLD;
			end
			S_STEP: begin
				cmd.step = sts.out_free;
				if (sts.out_free && sts.last_step) state_d = S_IDLE;
			end
			S_HOLD: begin
				cmd.idle_emit = sts.out_free;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/gpsc_datapath.sv =====
// Datapath: registers, readings, debounce, target mapping, stepping and output word.
`default_nettype none

module gpsc_datapath
	import gpsc_pkg::*;
#(
	parameter int POSITION_WIDTH = PosWidthDefault
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [15:0]               cfg_data,
	input  wire logic                      sensor_valid,
	input  wire logic [7:0]                moisture,
	input  wire logic [7:0]                light,
	input  wire logic [7:0]                health,
	input  wire logic                      button_level,
	input  wire gpsc_cmd_t                 cmd,
	output gpsc_sts_t                      sts,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output logic [3:0]                     coil_pattern,
	output logic                           step_taken,
	output logic [POSITION_WIDTH-1:0]      position,
	output logic [POSITION_WIDTH-1:0]      target,
	output logic [1:0]                     mode,
	output logic [2:0]                     led_rgb,
	output logic                           last
);

	localparam int PW = POSITION_WIDTH;

	// configuration
	logic [15:0] step_interval_q;
	logic [3:0]  chunk_steps_q;
	logic [9:0]  debounce_time_q;
	logic [9:0]  full_scale_q;

	// state
	logic [1:0]    mode_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] target_q;
	logic [1:0]    phase_q;
	logic [7:0]    readings_q [3];
	logic [15:0]   chunk_q;
	logic [9:0]    deb_q;
	logic          prev_raw_q;
	logic          stable_q;
	logic          sense_q;
	logic          raw_q;
	logic          up_q;
	logic [3:0]    steps_left_q;

	// retarget pipeline
	logic [16:0] prod_s1;
	logic [9:0]  quot_s2;

	// output word
	logic          out_valid_q;
	logic [3:0]    out_coil_q;
	logic          out_step_q;
	logic [PW-1:0] out_pos_q;
	logic [PW-1:0] out_tgt_q;
	logic [1:0]    out_mode_q;
	logic          out_last_q;

	localparam logic [PosWidthMax-1:0] TargetResetWide = PosWidthMax'(FullScaleReset);

	// reading of the current mode, clamped
	logic [7:0]  pct_raw;
	logic [6:0]  pct;
	logic [34:0] qprod;
	logic [PosWidthMax-1:0] diff_wide;

	always_comb begin
		case (mode_q)
			MODE_LIGHT:  pct_raw = readings_q[1];
			MODE_HEALTH: pct_raw = readings_q[2];
			default:     pct_raw = readings_q[0];
		endcase
		pct       = (pct_raw > 8'(PctMax)) ? PctMax : pct_raw[6:0];
		qprod     = 35'(prod_s1) * 35'(Recip100);
		diff_wide = PosWidthMax'(full_scale_q) - PosWidthMax'(quot_s2);
	end

	// debounce
	logic [9:0] deb_next;
	logic       level_take;
	assign deb_next   = (raw_q != prev_raw_q) ? 10'd0 :
	                    ((deb_q == DebounceSat) ? deb_q : deb_q + 10'd1);
	assign level_take = (deb_next > debounce_time_q) && (raw_q != stable_q);

	// chunk decision
	logic [15:0]   chunk_next;
	logic          go;
	logic          up;
	logic [PW-1:0] span;
	logic [3:0]    limit;
	logic [3:0]    n;
	assign chunk_next = (chunk_q == ChunkSat) ? chunk_q : chunk_q + 16'd1;
	assign go         = (pos_q != target_q) && (chunk_next >= step_interval_q);
	assign up         = target_q > pos_q;
	assign span       = up ? (target_q - pos_q) : (pos_q - target_q);
	assign limit      = (chunk_steps_q == 4'd0) ? 4'd1 :
	                    ((chunk_steps_q > MaxChunk) ? MaxChunk : chunk_steps_q);
	assign n          = (span < PW'(limit)) ? span[3:0] : limit;

	// one step
	logic [PW-1:0] pos_step;
	logic [1:0]    phase_step;
	assign pos_step   = up_q ? pos_q + PW'(1) : pos_q - PW'(1);
	assign phase_step = up_q ? phase_q + 2'd1 : phase_q - 2'd1;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.sensor    = sense_q;
		sts.press     = level_take && !raw_q;
		sts.go        = go;
		sts.last_step = (steps_left_q == 4'd1);
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_q <= StepIntervalReset;
			chunk_steps_q   <= ChunkStepsReset;
			debounce_time_q <= DebounceReset;
			full_scale_q    <= FullScaleReset;
			mode_q          <= MODE_MOISTURE;
			pos_q           <= '0;
			target_q        <= TargetResetWide[PW-1:0];
			phase_q         <= 2'd0;
			readings_q[0]   <= 8'd0;
			readings_q[1]   <= 8'd0;
			readings_q[2]   <= 8'd0;
			chunk_q         <= ChunkSat;
			deb_q           <= DebounceSat;
			prev_raw_q      <= 1'b1;
			stable_q        <= 1'b1;
			sense_q         <= 1'b0;
			raw_q           <= 1'b1;
			up_q            <= 1'b0;
			steps_left_q    <= 4'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP_INTERVAL: step_interval_q <= cfg_data;
					CFG_CHUNK_STEPS:   chunk_steps_q   <= cfg_data[3:0];
					CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_data[9:0];
					CFG_FULL_SCALE:    full_scale_q    <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (cmd.capture) begin
				sense_q <= sensor_valid;
				raw_q   <= button_level;
				if (sensor_valid) begin
					readings_q[0] <= moisture;
					readings_q[1] <= light;
					readings_q[2] <= health;
				end
			end
			if (cmd.rt_sub) target_q <= diff_wide[PW-1:0];
			if (cmd.btn_eval) begin
				deb_q      <= deb_next;
				prev_raw_q <= raw_q;
				if (level_take) begin
					stable_q <= raw_q;
					if (!raw_q) mode_q <= (mode_q >= MODE_HEALTH) ? MODE_MOISTURE :
					                      mode_q + 2'd1;
				end
			end
			if (cmd.motion_eval) begin
				chunk_q <= go ? 16'd0 : chunk_next;
				if (go) begin
					up_q         <= up;
					steps_left_q <= n;
				end
			end
			if (cmd.step) begin
				pos_q        <= pos_step;
				phase_q      <= phase_step;
				steps_left_q <= steps_left_q - 4'd1;
			end
			if (cmd.step || cmd.idle_emit) out_valid_q <= 1'b1;
			else if (!out_stall)           out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.rt_mul) prod_s1 <= 17'(pct) * 17'(full_scale_q);
		if (cmd.rt_div) quot_s2 <= qprod[RecipShift+9:RecipShift];
		if (cmd.step) begin
			out_coil_q <= coil_of(phase_step);
			out_step_q <= 1'b1;
			out_pos_q  <= pos_step;
			out_tgt_q  <= target_q;
			out_mode_q <= mode_q;
			out_last_q <= (steps_left_q == 4'd1);
		end else if (cmd.idle_emit) begin
			out_coil_q <= coil_of(phase_q);
			out_step_q <= 1'b0;
			out_pos_q  <= pos_q;
			out_tgt_q  <= target_q;
			out_mode_q <= mode_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign coil_pattern = out_coil_q;
	assign step_taken   = out_step_q;
	assign position     = out_pos_q;
	assign target       = out_tgt_q;
	assign mode         = out_mode_q;
	assign led_rgb      = led_of(out_mode_q);
	assign last         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/gauge_pointer_stepper_controller_top.sv =====
// Top level of the gauge pointer stepper controller: sequencer plus datapath.
// Sequence: a tick is taken in idle, then passes sense, button and motion evaluation,
//   then its steps or one idle word; each target remap (sensor update, mode change) adds
//   multiply, divide and subtract states, at most two remaps per tick.
// Steps: at most 10 per tick, one per cycle through the output register unless stalled.
// Reset: arst_n clears all but payload registers; target starts at 350, mode at moisture.
`default_nettype none

module gauge_pointer_stepper_controller_top
	import gpsc_pkg::*;
#(
	parameter int POSITION_WIDTH = PosWidthDefault
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write port
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [15:0]               cfg_data,
	// tick input channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      sensor_valid,
	input  wire logic [7:0]                moisture,
	input  wire logic [7:0]                light,
	input  wire logic [7:0]                health,
	input  wire logic                      button_level,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [3:0]                     coil_pattern,
	output logic                           step_taken,
	output logic [POSITION_WIDTH-1:0]      position,
	output logic [POSITION_WIDTH-1:0]      target,
	output logic [1:0]                     mode,
	output logic [2:0]                     led_rgb,
	output logic                           last
);

	// Commands flow from the sequencer to the datapath, status flows back.
	gpsc_cmd_t cmd;
	gpsc_sts_t sts;

	// Sequencer: take one word, remap on sensor update or mode change, debounce the button,
	// decide on a chunk, then drain one step per cycle to the output register unless stalled.
	gpsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: holds configuration, readings, pointer state and the output word.
	// The output register lets a new tick be taken while the last word waits.
	gpsc_datapath #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sensor_valid (sensor_valid),
		.moisture     (moisture),
		.light        (light),
		.health       (health),
		.button_level (button_level),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.coil_pattern (coil_pattern),
		.step_taken   (step_taken),
		.position     (position),
		.target       (target),
		.mode         (mode),
		.led_rgb      (led_rgb),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== rtl/core/gpsc_checker.sv =====
// Port-level checker of the gauge pointer stepper controller and its bind.
`default_nettype none

module gpsc_checker
	import gpsc_pkg::*;
#(
	parameter int POSITION_WIDTH = PosWidthDefault
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [3:0]                coil_pattern,
	input wire logic                      step_taken,
	input wire logic [POSITION_WIDTH-1:0] position,
	input wire logic [POSITION_WIDTH-1:0] target,
	input wire logic [1:0]                mode,
	input wire logic [2:0]                led_rgb,
	input wire logic                      last
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(last)
			&& $stable(coil_pattern) && $stable(step_taken))
		else $error("stalled result word changed");

	// a taken tick keeps the block busy for at least the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// an idle result always closes its tick
	a_idle_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !step_taken |-> last)
		else $error("idle result without last");

	// more steps of the same tick pending: no new tick taken
	a_no_take_mid_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_taken && !last |-> in_stall)
		else $error("input taken while a chunk is in progress");

	// LED color follows the mode
	a_led_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (led_rgb == led_of(mode)) && (mode != 2'd3))
		else $error("LED color does not match mode");

endmodule

bind gauge_pointer_stepper_controller_top gpsc_checker #(
	.POSITION_WIDTH (POSITION_WIDTH)
) u_gpsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.coil_pattern (coil_pattern),
	.step_taken   (step_taken),
	.position     (position),
	.target       (target),
	.mode         (mode),
	.led_rgb      (led_rgb),
	.last         (last)
);

`default_nettype wire
